// File: sv/hee_pkg.sv
// Package for the character entity encoder: widths, ROM lookup, run types.
// No dependencies.
package hee_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned ImmW       = 64;
  localparam int unsigned CntW       = 4;
  localparam int unsigned MaxImmune  = 8;
  localparam int unsigned MaxRun     = 10;
  localparam int unsigned NameMax    = 8;
  localparam int unsigned PosW       = 4;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChX    = 8'h78;

  localparam logic [1:0] KindPass = 2'd0;
  localparam logic [1:0] KindName = 2'd1;
  localparam logic [1:0] KindHex  = 2'd2;

  localparam logic [0:0] RegImmChars = 1'b0;
  localparam logic [0:0] RegImmCount = 1'b1;

  typedef logic [NameMax*8-1:0] name_t;  // first char in low byte, zero padded

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           immune;
  } s1_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CpW-1:0]  cp;
    name_t           name;
    logic [PosW-1:0] len;   // number of result characters, minus one
  } run_t;

  function automatic name_t pk(input string s);
    name_t r;
    r = '0;
    for (int i = 0; i < s.len() && i < NameMax; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [7:0] hexc(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'h0, d};
    else r = 8'h57 + {4'h0, d};
    return r;
  endfunction

  function automatic logic is_alnum(input logic [CpW-1:0] c);
    return (c >= 21'd48 && c <= 21'd57) || (c >= 21'd65 && c <= 21'd90) ||
           (c >= 21'd97 && c <= 21'd122);
  endfunction

  // Named-entity ROM; returns zero when the code point has no name.
  function automatic name_t ent_name(input logic [CpW-1:0] c);
    name_t r;
    r = '0;
    case (c)
      21'd34: r = pk("quot"); 21'd38: r = pk("amp"); 21'd60: r = pk("lt");
      21'd62: r = pk("gt");
      21'd160: r = pk("nbsp"); 21'd161: r = pk("iexcl"); 21'd162: r = pk("cent");
      21'd163: r = pk("pound"); 21'd164: r = pk("curren"); 21'd165: r = pk("yen");
      21'd166: r = pk("brvbar"); 21'd167: r = pk("sect"); 21'd168: r = pk("uml");
      21'd169: r = pk("copy"); 21'd170: r = pk("ordf"); 21'd171: r = pk("laquo");
      21'd172: r = pk("not"); 21'd173: r = pk("shy"); 21'd174: r = pk("reg");
      21'd175: r = pk("macr"); 21'd176: r = pk("deg"); 21'd177: r = pk("plusmn");
      21'd178: r = pk("sup2"); 21'd179: r = pk("sup3"); 21'd180: r = pk("acute");
      21'd181: r = pk("micro"); 21'd182: r = pk("para"); 21'd183: r = pk("middot");
      21'd184: r = pk("cedil"); 21'd185: r = pk("sup1"); 21'd186: r = pk("ordm");
      21'd187: r = pk("raquo"); 21'd188: r = pk("frac14"); 21'd189: r = pk("frac12");
      21'd190: r = pk("frac34"); 21'd191: r = pk("iquest"); 21'd192: r = pk("Agrave");
      21'd193: r = pk("Aacute"); 21'd194: r = pk("Acirc"); 21'd195: r = pk("Atilde");
      21'd196: r = pk("Auml"); 21'd197: r = pk("Aring"); 21'd198: r = pk("AElig");
      21'd199: r = pk("Ccedil"); 21'd200: r = pk("Egrave"); 21'd201: r = pk("Eacute");
      21'd202: r = pk("Ecirc"); 21'd203: r = pk("Euml"); 21'd204: r = pk("Igrave");
      21'd205: r = pk("Iacute"); 21'd206: r = pk("Icirc"); 21'd207: r = pk("Iuml");
      21'd208: r = pk("ETH"); 21'd209: r = pk("Ntilde"); 21'd210: r = pk("Ograve");
      21'd211: r = pk("Oacute"); 21'd212: r = pk("Ocirc"); 21'd213: r = pk("Otilde");
      21'd214: r = pk("Ouml"); 21'd215: r = pk("times"); 21'd216: r = pk("Oslash");
      21'd217: r = pk("Ugrave"); 21'd218: r = pk("Uacute"); 21'd219: r = pk("Ucirc");
      21'd220: r = pk("Uuml"); 21'd221: r = pk("Yacute"); 21'd222: r = pk("THORN");
      21'd223: r = pk("szlig"); 21'd224: r = pk("agrave"); 21'd225: r = pk("aacute");
      21'd226: r = pk("acirc"); 21'd227: r = pk("atilde"); 21'd228: r = pk("auml");
      21'd229: r = pk("aring"); 21'd230: r = pk("aelig"); 21'd231: r = pk("ccedil");
      21'd232: r = pk("egrave"); 21'd233: r = pk("eacute"); 21'd234: r = pk("ecirc");
      21'd235: r = pk("euml"); 21'd236: r = pk("igrave"); 21'd237: r = pk("iacute");
      21'd238: r = pk("icirc"); 21'd239: r = pk("iuml"); 21'd240: r = pk("eth");
      21'd241: r = pk("ntilde"); 21'd242: r = pk("ograve"); 21'd243: r = pk("oacute");
      21'd244: r = pk("ocirc"); 21'd245: r = pk("otilde"); 21'd246: r = pk("ouml");
      21'd247: r = pk("divide"); 21'd248: r = pk("oslash"); 21'd249: r = pk("ugrave");
      21'd250: r = pk("uacute"); 21'd251: r = pk("ucirc"); 21'd252: r = pk("uuml");
      21'd253: r = pk("yacute"); 21'd254: r = pk("thorn"); 21'd255: r = pk("yuml");
      21'd338: r = pk("OElig"); 21'd339: r = pk("oelig"); 21'd352: r = pk("Scaron");
      21'd353: r = pk("scaron"); 21'd376: r = pk("Yuml"); 21'd402: r = pk("fnof");
      21'd710: r = pk("circ"); 21'd732: r = pk("tilde");
      21'd913: r = pk("Alpha"); 21'd914: r = pk("Beta"); 21'd915: r = pk("Gamma");
      21'd916: r = pk("Delta"); 21'd917: r = pk("Epsilon"); 21'd918: r = pk("Zeta");
      21'd919: r = pk("Eta"); 21'd920: r = pk("Theta"); 21'd921: r = pk("Iota");
      21'd922: r = pk("Kappa"); 21'd923: r = pk("Lambda"); 21'd924: r = pk("Mu");
      21'd925: r = pk("Nu"); 21'd926: r = pk("Xi"); 21'd927: r = pk("Omicron");
      21'd928: r = pk("Pi"); 21'd929: r = pk("Rho"); 21'd931: r = pk("Sigma");
      21'd932: r = pk("Tau"); 21'd933: r = pk("Upsilon"); 21'd934: r = pk("Phi");
      21'd935: r = pk("Chi"); 21'd936: r = pk("Psi"); 21'd937: r = pk("Omega");
      21'd945: r = pk("alpha"); 21'd946: r = pk("beta"); 21'd947: r = pk("gamma");
      21'd948: r = pk("delta"); 21'd949: r = pk("epsilon"); 21'd950: r = pk("zeta");
      21'd951: r = pk("eta"); 21'd952: r = pk("theta"); 21'd953: r = pk("iota");
      21'd954: r = pk("kappa"); 21'd955: r = pk("lambda"); 21'd956: r = pk("mu");
      21'd957: r = pk("nu"); 21'd958: r = pk("xi"); 21'd959: r = pk("omicron");
      21'd960: r = pk("pi"); 21'd961: r = pk("rho"); 21'd962: r = pk("sigmaf");
      21'd963: r = pk("sigma"); 21'd964: r = pk("tau"); 21'd965: r = pk("upsilon");
      21'd966: r = pk("phi"); 21'd967: r = pk("chi"); 21'd968: r = pk("psi");
      21'd969: r = pk("omega"); 21'd977: r = pk("thetasym"); 21'd978: r = pk("upsih");
      21'd982: r = pk("piv");
      21'd8194: r = pk("ensp"); 21'd8195: r = pk("emsp"); 21'd8201: r = pk("thinsp");
      21'd8204: r = pk("zwnj"); 21'd8205: r = pk("zwj"); 21'd8206: r = pk("lrm");
      21'd8207: r = pk("rlm"); 21'd8211: r = pk("ndash"); 21'd8212: r = pk("mdash");
      21'd8216: r = pk("lsquo"); 21'd8217: r = pk("rsquo"); 21'd8218: r = pk("sbquo");
      21'd8220: r = pk("ldquo"); 21'd8221: r = pk("rdquo"); 21'd8222: r = pk("bdquo");
      21'd8224: r = pk("dagger"); 21'd8225: r = pk("Dagger"); 21'd8226: r = pk("bull");
      21'd8230: r = pk("hellip"); 21'd8240: r = pk("permil"); 21'd8242: r = pk("prime");
      21'd8243: r = pk("Prime"); 21'd8249: r = pk("lsaquo"); 21'd8250: r = pk("rsaquo");
      21'd8254: r = pk("oline"); 21'd8260: r = pk("frasl"); 21'd8364: r = pk("euro");
      21'd8465: r = pk("image"); 21'd8472: r = pk("weierp"); 21'd8476: r = pk("real");
      21'd8482: r = pk("trade"); 21'd8501: r = pk("alefsym");
      21'd8592: r = pk("larr"); 21'd8593: r = pk("uarr"); 21'd8594: r = pk("rarr");
      21'd8595: r = pk("darr"); 21'd8596: r = pk("harr"); 21'd8629: r = pk("crarr");
      21'd8656: r = pk("lArr"); 21'd8657: r = pk("uArr"); 21'd8658: r = pk("rArr");
      21'd8659: r = pk("dArr"); 21'd8660: r = pk("hArr"); 21'd8704: r = pk("forall");
      21'd8706: r = pk("part"); 21'd8707: r = pk("exist"); 21'd8709: r = pk("empty");
      21'd8711: r = pk("nabla"); 21'd8712: r = pk("isin"); 21'd8713: r = pk("notin");
      21'd8715: r = pk("ni"); 21'd8719: r = pk("prod"); 21'd8721: r = pk("sum");
      21'd8722: r = pk("minus"); 21'd8727: r = pk("lowast"); 21'd8730: r = pk("radic");
      21'd8733: r = pk("prop"); 21'd8734: r = pk("infin"); 21'd8736: r = pk("ang");
      21'd8743: r = pk("and"); 21'd8744: r = pk("or"); 21'd8745: r = pk("cap");
      21'd8746: r = pk("cup"); 21'd8747: r = pk("int"); 21'd8756: r = pk("there4");
      21'd8764: r = pk("sim"); 21'd8773: r = pk("cong"); 21'd8776: r = pk("asymp");
      21'd8800: r = pk("ne"); 21'd8801: r = pk("equiv"); 21'd8804: r = pk("le");
      21'd8805: r = pk("ge"); 21'd8834: r = pk("sub"); 21'd8835: r = pk("sup");
      21'd8836: r = pk("nsub"); 21'd8838: r = pk("sube"); 21'd8839: r = pk("supe");
      21'd8853: r = pk("oplus"); 21'd8855: r = pk("otimes"); 21'd8869: r = pk("perp");
      21'd8901: r = pk("sdot"); 21'd8968: r = pk("lceil"); 21'd8969: r = pk("rceil");
      21'd8970: r = pk("lfloor"); 21'd8971: r = pk("rfloor"); 21'd9001: r = pk("lang");
      21'd9002: r = pk("rang"); 21'd9674: r = pk("loz"); 21'd9824: r = pk("spades");
      21'd9827: r = pk("clubs"); 21'd9829: r = pk("hearts"); 21'd9830: r = pk("diams");
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [PosW-1:0] name_len(input name_t n);
    logic [PosW-1:0] l;
    l = '0;
    for (int i = 0; i < NameMax; i++)
      if (n[i*8 +: 8] != 8'h00) l = PosW'(i + 1);
    return l;
  endfunction

endpackage

// File: sv/hee_if.sv
// Valid/ready channel interfaces for the entity encoder.
// Depends on hee_pkg.
interface hee_in_if;
  logic                     valid;
  logic                     ready;
  logic [hee_pkg::CpW-1:0]  code_point;
  modport source(output valid, output code_point, input ready);
  modport sink(input valid, input code_point, output ready);
endinterface

interface hee_out_if;
  logic                     valid;
  logic                     ready;
  logic [hee_pkg::CpW-1:0]  out_char;
  logic                     last;
  modport source(output valid, output out_char, output last, input ready);
  modport sink(input valid, input out_char, input last, output ready);
endinterface

interface hee_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/hee_classify.sv
// Front stages: immune match (stage 1), then ROM lookup and run setup (stage 2).
// Depends on hee_pkg.
module hee_classify #(
  parameter int unsigned MAX_IMMUNE = hee_pkg::MaxImmune
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [hee_pkg::CpW-1:0]     in_cp,
  output logic                        in_ready,
  input  logic [MAX_IMMUNE*8-1:0]     imm_chars,
  input  logic [hee_pkg::CntW-1:0]    imm_count,
  output logic                        run_valid,
  output hee_pkg::run_t               run,
  input  logic                        run_ready
);
  logic s1_valid_r;
  hee_pkg::s1_t s1_r;
  logic s2_valid_r;
  hee_pkg::run_t s2_r, s2_nxt;
  logic s1_ready, s2_ready;
  logic hit;
  logic [hee_pkg::CntW-1:0] n_eff;
  hee_pkg::name_t nm;

  assign s2_ready = !s2_valid_r || run_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    n_eff = (imm_count > hee_pkg::CntW'(MAX_IMMUNE)) ? hee_pkg::CntW'(MAX_IMMUNE) : imm_count;
    hit = 1'b0;
    for (int k = 0; k < MAX_IMMUNE; k++)
      if (hee_pkg::CntW'(k) < n_eff && in_cp < 21'd256 && in_cp[7:0] == imm_chars[k*8 +: 8])
        hit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_r.cp     <= in_cp;
      s1_r.immune <= hit;
    end
  end

  always_comb begin
    nm = hee_pkg::ent_name(s1_r.cp);
    s2_nxt.cp = s1_r.cp;
    s2_nxt.name = nm;
    if (s1_r.immune || (nm == '0 && hee_pkg::is_alnum(s1_r.cp))) begin
      s2_nxt.kind = hee_pkg::KindPass;
      s2_nxt.len  = '0;
    end else if (nm != '0) begin
      s2_nxt.kind = hee_pkg::KindName;
      s2_nxt.len  = hee_pkg::name_len(nm) + 4'd1;
    end else begin
      s2_nxt.kind = hee_pkg::KindHex;
      s2_nxt.len  = 4'd7;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
  end

  assign run_valid = s2_valid_r;
  assign run       = s2_r;
endmodule

// File: sv/hee_emit.sv
// Back stages: steps through one run per character, registered output.
// Depends on hee_pkg.
module hee_emit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    run_valid,
  input  hee_pkg::run_t           run,
  output logic                    run_ready,
  output logic                    out_valid,
  output logic [hee_pkg::CpW-1:0] out_char,
  output logic                    out_last,
  input  logic                    out_ready
);
  logic busy_r;
  hee_pkg::run_t cur_r;
  logic [hee_pkg::PosW-1:0] pos_r, pos_nxt;
  logic ov_r;
  logic [hee_pkg::CpW-1:0] oc_r;
  logic ol_r;
  logic o_ready, step, done;
  logic [hee_pkg::CpW-1:0] ch;
  logic [15:0] lo;
  logic [3:0] nib;

  assign o_ready = !ov_r || out_ready;
  assign step = busy_r && o_ready;
  assign done = (pos_r == cur_r.len);
  assign run_ready = !busy_r || (step && done);
  assign pos_nxt = pos_r + 4'd1;
  assign lo = cur_r.cp[15:0];

  always_comb begin
    ch = '0;
    nib = '0;
    case (cur_r.kind)
      hee_pkg::KindPass: ch = cur_r.cp;
      hee_pkg::KindName: begin
        if (pos_r == 4'd0) ch = 21'(hee_pkg::ChAmp);
        else if (done) ch = 21'(hee_pkg::ChSemi);
        else ch = 21'(cur_r.name[{pos_r[2:0] - 3'd1, 3'b000} +: 8]);
      end
      default: begin
        case (pos_r)
          4'd0: ch = 21'(hee_pkg::ChAmp);
          4'd1: ch = 21'(hee_pkg::ChHash);
          4'd2: ch = 21'(hee_pkg::ChX);
          4'd3: nib = lo[15:12];
          4'd4: nib = lo[11:8];
          4'd5: nib = lo[7:4];
          4'd6: nib = lo[3:0];
          default: ch = 21'(hee_pkg::ChSemi);
        endcase
        if (pos_r >= 4'd3 && pos_r <= 4'd6) ch = 21'(hee_pkg::hexc(nib));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (run_ready) busy_r <= run_valid;
      else if (step) busy_r <= 1'b1;
      if (o_ready) ov_r <= step;
    end
    if (run_ready && run_valid) begin
      cur_r <= run;
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
    if (step) begin
      oc_r <= ch;
      ol_r <= done;
    end
  end

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;
endmodule

// File: sv/html_entity_encoder_core.sv
// HTML character entity encoder, top level.
// Depends on hee_pkg, hee_if, hee_classify, hee_emit.
//
// Usage: each transaction on the in_ channel carries one code point. It
// produces a run of one to ten transactions on the out_ channel: the
// character itself, '&' name ';' for a named entity, or '&#x' plus four
// lowercase hex digits and ';'. last marks the final character of a run.
// The cfg_ channel writes register 0 (immune characters, slot 0 in the low
// byte) and register 1 (immune count); write only while the block is idle.
// The first character of a run passes in order through the immune match, ROM
// lookup, run sequencer and output register.
// Throughput: one output character per cycle while the receiver is ready, set
// by the run sequencer; a single-character run therefore sustains one input per
// cycle, while a longer run holds the input until its last character is sent.
// Reset (synchronous, rst_n low) clears both registers and all valid bits.
// When the receiver stalls, each stage holds its contents and ready backs
// up toward the input; nothing is dropped or repeated.
module html_entity_encoder_core #(
  parameter int unsigned MAX_IMMUNE = hee_pkg::MaxImmune
) (
  input  logic      clk,
  input  logic      rst_n,
  hee_in_if.sink    in_ch,
  hee_out_if.source out_ch,
  hee_cfg_if.sink   cfg_ch
);
  logic [hee_pkg::ImmW-1:0] imm_chars_r;
  logic [hee_pkg::CntW-1:0] imm_count_r;
  logic run_valid, run_ready;
  hee_pkg::run_t run;

  // Configuration is always accepted.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imm_chars_r <= '0;
      imm_count_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        hee_pkg::RegImmChars: imm_chars_r <= cfg_ch.data;
        hee_pkg::RegImmCount: imm_count_r <= cfg_ch.data[hee_pkg::CntW-1:0];
      endcase
    end
  end

  hee_classify #(.MAX_IMMUNE(MAX_IMMUNE)) u_classify (
    .clk, .rst_n,
    .in_valid  (in_ch.valid),
    .in_cp     (in_ch.code_point),
    .in_ready  (in_ch.ready),
    .imm_chars (imm_chars_r[MAX_IMMUNE*8-1:0]),
    .imm_count (imm_count_r),
    .run_valid, .run, .run_ready
  );

  hee_emit u_emit (
    .clk, .rst_n,
    .run_valid, .run, .run_ready,
    .out_valid (out_ch.valid),
    .out_char  (out_ch.out_char),
    .out_last  (out_ch.last),
    .out_ready (out_ch.ready)
  );
endmodule

// File: sv/hee_checker.sv
// Port-level assertions for the entity encoder, bound to the top level.
// Depends on hee_pkg; checks html_entity_encoder_core ports only.
module hee_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_last,
  input logic [hee_pkg::CpW-1:0] out_char,
  input logic                    cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last && out_char == 21'h3B |-> 1'b0)
    else $error("semicolon inside a run");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration refused");
endmodule

bind html_entity_encoder_core hee_checker u_hee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last),
  .out_char  (out_ch.out_char),
  .cfg_ready (cfg_ch.ready)
);
